// ===== hw/rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int unsigned OperandWidth = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;
endpackage

// ===== hw/rtl/rau_front.sv =====
// Front end: accepts requests, forms the exact signed-magnitude cross products and sums them.
// Depends on rau_pkg. Feeds rau_fifo.
module rau_front #(
  parameter int unsigned W = rau_pkg::OperandWidth,
  localparam int unsigned MW = 2 * W + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [W-1:0]  an_i,
  input  logic [W-1:0]  ad_i,
  input  logic [W-1:0]  bn_i,
  input  logic [W-1:0]  bd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2*MW+2:0] out_data_o
);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_OUT} state_e;
  state_e state_q;
  logic [1:0] op_q;
  logic [W:0] m_q [4];
  logic s_q [4];
  logic [2*W-1:0] p1_q, p2_q, pd_q;
  logic n1_q, n2_q, nd_q;
  logic err_q;
  logic [MW-1:0] nm_q;
  logic nn_q;

  function automatic logic [W:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = {err_q, nn_q, nm_q, nd_q, {1'b0, pd_q}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q <= kind_i;
            m_q[0] <= mag(an_i); s_q[0] <= an_i[W-1];
            m_q[1] <= mag(ad_i); s_q[1] <= ad_i[W-1];
            m_q[2] <= mag(bn_i); s_q[2] <= bn_i[W-1];
            m_q[3] <= mag(bd_i); s_q[3] <= bd_i[W-1];
            err_q <= (ad_i == '0) || (bd_i == '0) ||
                     ((kind_i == rau_pkg::OP_DIV) && (bn_i == '0));
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          case (rau_pkg::op_e'(op_q))
            rau_pkg::OP_MUL: begin
              p1_q <= (2*W)'(m_q[0] * m_q[2]); n1_q <= s_q[0] ^ s_q[2];
              p2_q <= '0; n2_q <= 1'b0;
              pd_q <= (2*W)'(m_q[1] * m_q[3]); nd_q <= s_q[1] ^ s_q[3];
            end
            rau_pkg::OP_DIV: begin
              p1_q <= (2*W)'(m_q[0] * m_q[3]); n1_q <= s_q[0] ^ s_q[3];
              p2_q <= '0; n2_q <= 1'b0;
              pd_q <= (2*W)'(m_q[1] * m_q[2]); nd_q <= s_q[1] ^ s_q[2];
            end
            default: begin
              p1_q <= (2*W)'(m_q[0] * m_q[3]); n1_q <= s_q[0] ^ s_q[3];
              p2_q <= (2*W)'(m_q[2] * m_q[1]);
              n2_q <= s_q[2] ^ s_q[1] ^ (op_q == rau_pkg::OP_SUB);
              pd_q <= (2*W)'(m_q[1] * m_q[3]); nd_q <= s_q[1] ^ s_q[3];
            end
          endcase
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (n1_q == n2_q) begin
            nm_q <= MW'(p1_q) + MW'(p2_q); nn_q <= n1_q;
          end else if (p1_q >= p2_q) begin
            nm_q <= MW'(p1_q - p2_q); nn_q <= n1_q;
          end else begin
            nm_q <= MW'(p2_q - p1_q); nn_q <= n2_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/rau_fifo.sv =====
// Two-entry queue between front end and back end.
// No dependencies.
module rau_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [DW-1:0] in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] out_data_o
);
  logic [DW-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) begin
        mem_q[wp_q] <= in_data_i;
        wp_q <= ~wp_q;
      end
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== hw/rtl/rau_back.sv =====
// Back end: binary GCD, two restoring divisions, sign normalization.
// Depends on rau_pkg via parameters only.
module rau_back #(
  parameter int unsigned W = rau_pkg::OperandWidth,
  localparam int unsigned MW = 2 * W + 1,
  localparam int unsigned CW = $clog2(MW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2*MW+2:0] in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [MW-1:0]   num_o,
  output logic [MW-3:0]   den_o,
  output logic            err_o
);
  typedef enum logic [2:0] {S_IDLE, S_GCD, S_DIVN, S_DIVD, S_OUT} state_e;
  state_e state_q;
  logic [MW-1:0] nm_q, dm_q, x_q, y_q, q_q, r_q;
  logic [CW-1:0] k_q, i_q;
  logic neg_q, err_q;
  logic [MW-1:0] num_q;
  logic [MW-3:0] den_q;
  logic [MW:0] rs;
  logic [MW-1:0] dv;
  logic qb;
  logic [MW-1:0] rn;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign num_o = num_q;
  assign den_o = den_q;
  assign err_o = err_q;
  assign dv = x_q << k_q;
  assign rs = {r_q, q_q[MW-1]};
  assign qb = (rs >= {1'b0, dv});
  assign rn = qb ? MW'(rs - {1'b0, dv}) : rs[MW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            dm_q  <= in_data_i[MW-1:0];
            nm_q  <= in_data_i[2*MW:MW+1];
            neg_q <= in_data_i[MW] ^ in_data_i[2*MW+1];
            err_q <= in_data_i[2*MW+2];
            x_q <= in_data_i[2*MW:MW+1];
            y_q <= in_data_i[MW-1:0];
            k_q <= '0;
            if (in_data_i[2*MW+2] || in_data_i[2*MW:MW+1] == '0) begin
              num_q <= '0; den_q <= (MW-2)'(1);
              state_q <= S_OUT;
            end else begin
              state_q <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (x_q == y_q) begin
            q_q <= nm_q; r_q <= '0; i_q <= '0;
            state_q <= S_DIVN;
          end else if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1; y_q <= y_q >> 1; k_q <= k_q + 1'b1;
          end else if (!x_q[0]) begin
            x_q <= x_q >> 1;
          end else if (!y_q[0]) begin
            y_q <= y_q >> 1;
          end else if (x_q > y_q) begin
            x_q <= (x_q - y_q) >> 1;
          end else begin
            y_q <= (y_q - x_q) >> 1;
          end
        end
        S_DIVN, S_DIVD: begin
          if (i_q == CW'(MW - 1)) begin
            i_q <= '0; r_q <= '0;
            if (state_q == S_DIVN) begin
              nm_q <= {q_q[MW-2:0], qb};
              q_q <= dm_q;
              state_q <= S_DIVD;
            end else begin
              if (!neg_q) num_q <= nm_q;
              else num_q <= MW'(~nm_q + 1'b1);
              den_q <= {q_q[MW-4:0], qb};
              state_q <= S_OUT;
            end
          end else begin
            r_q <= rn; q_q <= {q_q[MW-2:0], qb};
            i_q <= i_q + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit: front end, queue, back end.
// Depends on rau_pkg, rau_front, rau_fifo, rau_back.
//
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata: an, ad, bn, bd; tuser: kind
// m_axis  | out | m_axis_tvalid/tready   | tdata: result_numerator, result_denominator; tuser: error
//
// Front end handles one request at a time in four steps: capture, multiply, add, hand-off.
// Back end: binary GCD, then two restoring divisions of 2*OPERAND_WIDTH+1
// quotient bits each, for the numerator and then the denominator.
// Errors and zero numerators skip the back-end loops. Reset is asynchronous.
// A two-entry queue lets the front end take requests while the back end stalls.
module rational_arithmetic_unit_top #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth,
  localparam int unsigned MW = 2 * OPERAND_WIDTH + 1,
  localparam int unsigned IB = (4 * OPERAND_WIDTH + 7) / 8 * 8,
  localparam int unsigned OB = (2 * MW - 2 + 7) / 8 * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [IB-1:0] s_axis_tdata,  // a_numerator, a_denominator, b_numerator, b_denominator
  input  logic [1:0]    s_axis_tuser,  // kind
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [OB-1:0] m_axis_tdata,  // result_numerator, result_denominator
  output logic          m_axis_tuser   // error
);
  localparam int unsigned W = OPERAND_WIDTH;
  logic fv, fr, bv, br;
  logic [2*MW+2:0] fd, bd;
  logic [MW-1:0] num;
  logic [MW-3:0] den;

  rau_front #(.W(W)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tuser),
    .an_i(s_axis_tdata[W-1:0]), .ad_i(s_axis_tdata[2*W-1:W]),
    .bn_i(s_axis_tdata[3*W-1:2*W]), .bd_i(s_axis_tdata[4*W-1:3*W]),
    .out_valid_o(fv), .out_ready_i(fr), .out_data_o(fd)
  );

  rau_fifo #(.DW(2*MW+3)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(fv), .in_ready_o(fr), .in_data_i(fd),
    .out_valid_o(bv), .out_ready_i(br), .out_data_o(bd)
  );

  rau_back #(.W(W)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(bv), .in_ready_o(br), .in_data_i(bd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .num_o(num), .den_o(den), .err_o(m_axis_tuser)
  );

  assign m_axis_tdata = OB'({den, num});
endmodule

// ===== hw/rtl/rau_checker.sv =====
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rational_arithmetic_unit_top.
module rau_checker #(
  parameter int unsigned OPERAND_WIDTH = 16,
  localparam int unsigned MW = 2 * OPERAND_WIDTH + 1,
  localparam int unsigned OB = (2 * MW - 2 + 7) / 8 * 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [OB-1:0] m_axis_tdata,
  input logic          m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2*MW-3:MW] != '0)
    else $error("zero denominator");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[MW-1:0] == '0)
    else $error("error result not zero");
endmodule

bind rational_arithmetic_unit_top rau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_chk (.*);
